FILE: design/fhfa_pkg.sv
// shared types and constants for the free hole fit allocator
package fhfa_pkg;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 32;
    localparam int IDX_W  = 4;
    localparam int WIDE_IDX_W = 9;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] ST_ALLOCATED     = 2'd0;
    localparam logic [1:0] ST_OUT_OF_MEMORY = 2'd1;
    localparam logic [1:0] ST_LOADED        = 2'd2;

    localparam logic CMD_ALLOCATE = 1'b0;
    localparam logic CMD_LOAD     = 1'b1;

    typedef struct packed {
        logic capture;
        logic issue_rd;
        logic finish;
    } fhfa_cmd_t;

    typedef struct packed {
        logic is_load;
        logic last_addr;
        logic out_busy;
    } fhfa_status_t;

endpackage

FILE: design/fhfa_ram.sv
// generic single write port ram with registered read
module fhfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/fhfa_ctrl.sv
// sequencer for load and allocate beats
module fhfa_ctrl
    import fhfa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  fhfa_status_t status,
    output fhfa_cmd_t    cmd
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.issue_rd = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = status.is_load ? FINISH : SCAN;
                end
            end
            SCAN: begin
                cmd.issue_rd = 1'b1;
                if (status.last_addr) begin
                    state_next = DRAIN;
                end
            end
            DRAIN: begin
                state_next = FINISH;
            end
            FINISH: begin
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == IDLE);

endmodule

FILE: design/fhfa_datapath.sv
// hole table, fit comparison, writeback and result register
module fhfa_datapath
    import fhfa_pkg::*;
#(
    parameter int HOLES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fhfa_cmd_t             cmd,
    output fhfa_status_t          status,
    input  logic                  in_cmd,
    input  logic [SIZE_W-1:0]     in_segment_size,
    input  logic [IDX_W-1:0]      in_entry_index,
    input  logic [ADDR_W-1:0]     in_entry_base,
    input  logic [SIZE_W-1:0]     in_entry_size,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_wdata,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_status,
    output logic [ADDR_W-1:0]     out_base_address,
    output logic [IDX_W-1:0]      out_hole_slot
);

    localparam int SLOT_W = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int ENTRY_W = ADDR_W + SIZE_W;

    logic [1:0]            fit_policy_reg;
    logic                  cmd_reg;
    logic [SIZE_W-1:0]     need_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [ADDR_W-1:0]     ebase_reg;
    logic [SIZE_W-1:0]     esize_reg;

    logic [HOLES-1:0]      valid_reg;
    logic [SLOT_W-1:0]     scan_cnt_reg;
    logic                  rd_pend_reg;
    logic                  rd_vld_reg;
    logic [SLOT_W-1:0]     rd_idx_reg;

    logic                  found_reg;
    logic [SLOT_W-1:0]     chosen_idx_reg;
    logic [ADDR_W-1:0]     chosen_base_reg;
    logic [SIZE_W-1:0]     chosen_size_reg;

    logic                  m_valid_reg;
    logic [1:0]            m_status_reg;
    logic [ADDR_W-1:0]     m_base_reg;
    logic [IDX_W-1:0]      m_slot_reg;

    logic [ENTRY_W-1:0]    rd_data;
    logic [ADDR_W-1:0]     rd_base;
    logic [SIZE_W-1:0]     rd_size;
    logic                  fits;
    logic                  better;
    logic                  take;

    logic [WIDE_IDX_W-1:0] load_idx_wide;
    logic                  load_ok;
    logic [WIDE_IDX_W-1:0] chosen_wide;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]    wr_data;

    fhfa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(HOLES)
    ) u_table (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(scan_cnt_reg),
        .rdata(rd_data)
    );

    // entries never written read as an empty hole
    assign rd_base = rd_vld_reg ? rd_data[ENTRY_W-1:SIZE_W] : '0;
    assign rd_size = rd_vld_reg ? rd_data[SIZE_W-1:0] : '0;

    assign fits = (rd_size != '0) && (rd_size >= need_reg);

    always_comb begin
        case (fit_policy_reg)
            FIT_BEST:  better = !found_reg || (rd_size < chosen_size_reg);
            FIT_WORST: better = !found_reg || (rd_size > chosen_size_reg);
            default:   better = !found_reg;
        endcase
    end

    assign take = rd_pend_reg && fits && better;

    assign load_idx_wide = {{(WIDE_IDX_W - IDX_W){1'b0}}, idx_reg};
    assign load_ok       = (load_idx_wide < WIDE_IDX_W'(HOLES));
    assign chosen_wide   = {{(WIDE_IDX_W - SLOT_W){1'b0}}, chosen_idx_reg};

    always_comb begin
        if (cmd_reg == CMD_LOAD) begin
            wr_en   = cmd.finish && load_ok;
            wr_addr = load_idx_wide[SLOT_W-1:0];
            wr_data = {ebase_reg, esize_reg};
        end else begin
            wr_en   = cmd.finish && found_reg;
            wr_addr = chosen_idx_reg;
            wr_data = {chosen_base_reg + need_reg, chosen_size_reg - need_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_policy_reg <= FIT_FIRST;
            valid_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            scan_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                fit_policy_reg <= cfg_wdata;
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_pend_reg <= cmd.issue_rd;
            if (cmd.capture) begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end else begin
                if (cmd.issue_rd) begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (take) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_vld_reg <= valid_reg[scan_cnt_reg];
        rd_idx_reg <= scan_cnt_reg;
        if (cmd.capture) begin
            cmd_reg   <= in_cmd;
            need_reg  <= in_segment_size;
            idx_reg   <= in_entry_index;
            ebase_reg <= in_entry_base;
            esize_reg <= in_entry_size;
        end
        if (take) begin
            chosen_idx_reg  <= rd_idx_reg;
            chosen_base_reg <= rd_base;
            chosen_size_reg <= rd_size;
        end
        if (cmd.finish) begin
            if (cmd_reg == CMD_LOAD) begin
                m_status_reg <= ST_LOADED;
                m_base_reg   <= '0;
                m_slot_reg   <= '0;
            end else if (found_reg) begin
                m_status_reg <= ST_ALLOCATED;
                m_base_reg   <= chosen_base_reg;
                m_slot_reg   <= chosen_wide[IDX_W-1:0];
            end else begin
                m_status_reg <= ST_OUT_OF_MEMORY;
                m_base_reg   <= '0;
                m_slot_reg   <= '0;
            end
        end
    end

    assign status.is_load   = (in_cmd == CMD_LOAD);
    assign status.last_addr = (scan_cnt_reg == SLOT_W'(HOLES - 1));
    assign status.out_busy  = m_valid_reg && !out_ready;

    assign out_valid        = m_valid_reg;
    assign out_status       = m_status_reg;
    assign out_base_address = m_base_reg;
    assign out_hole_slot    = m_slot_reg;

endmodule

FILE: design/free_hole_fit_allocator.sv
// top level of the free hole fit allocator
//
// Keeps a table of HOLES free holes (base, size; size zero is empty) and
// serves one beat at a time. A load beat writes one table slot and its
// result is registered from the FINISH state. An allocate beat scans the
// whole table serially, one entry per cycle through the single read port of
// the table ram, then writes back the shrunk hole if one fits; its result
// follows the SCAN, DRAIN and FINISH states. The controller returns to
// IDLE, and so is ready for the next beat, on the edge that loads the result.
// A stalled result holds the next beat in FINISH until the result is
// taken. The table starts empty after reset through per-slot valid bits, so
// no clearing pass is needed. fit_policy is written through cfg_we /
// cfg_wdata while idle: the user must keep to this, as the block itself
// does not enforce it.
module free_hole_fit_allocator
    import fhfa_pkg::*;
#(
    parameter int HOLES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // segment_size[31:0], entry_index[35:32], entry_base[67:36],
    // entry_size[99:68], zero fill
    input  logic [103:0] s_tdata,
    // cmd[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // base_address[31:0], hole_slot[35:32], zero fill
    output logic [39:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);

    fhfa_cmd_t       cmd;
    fhfa_status_t    status;
    logic [ADDR_W-1:0] base_address;
    logic [IDX_W-1:0]  hole_slot;

    fhfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    fhfa_datapath #(
        .HOLES(HOLES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_cmd          (s_tuser[0]),
        .in_segment_size (s_tdata[31:0]),
        .in_entry_index  (s_tdata[35:32]),
        .in_entry_base   (s_tdata[67:36]),
        .in_entry_size   (s_tdata[99:68]),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_status      (m_tuser),
        .out_base_address(base_address),
        .out_hole_slot   (hole_slot)
    );

    assign m_tdata = {4'b0000, hole_slot, base_address};

endmodule

FILE: design/fhfa_checker.sv
// port level checks for the free hole fit allocator and their bind
module fhfa_checker
    import fhfa_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata,
    input logic [1:0]   m_tuser
);

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // only an allocation carries a base and a slot
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_ALLOCATED) |-> (m_tdata == '0))
        else $error("non-allocation result carries a payload");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_ALLOCATED) || (m_tuser == ST_OUT_OF_MEMORY)
                     || (m_tuser == ST_LOADED))
        else $error("unknown result status");

    // one beat in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous beat still in work");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind free_hole_fit_allocator fhfa_checker u_fhfa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
